### rtl/median3_glitch_reject_filter_unit_defines.svh
// assertion macros for the median-of-three glitch reject filter
// used by the port checker; depends on nothing
`ifndef MEDIAN3_GLITCH_REJECT_FILTER_UNIT_DEFINES_SVH
`define MEDIAN3_GLITCH_REJECT_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MGRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mgrf port check failed");

// next-cycle implication, disabled during reset
`define MGRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mgrf port check failed");

`endif

### rtl/mgrf_pkg.sv
// shared types, widths and helpers for the median-of-three glitch reject filter
// no dependencies
package mgrf_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int THRESH_W     = 31;
    localparam int PTR_W        = 2;
    localparam int DIFF_W       = SAMPLE_W + 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [THRESH_W-1:0] t_thresh;
    typedef logic        [PTR_W-1:0]    t_ptr;
    typedef logic        [DIFF_W-1:0]   t_diff;

    localparam t_thresh THRESH_RESET = t_thresh'(1000);

    // window slot codes
    localparam t_ptr SLOT_0 = t_ptr'(0);
    localparam t_ptr SLOT_1 = t_ptr'(1);
    localparam t_ptr SLOT_2 = t_ptr'(2);

    // signed median of three values
    function automatic t_sample median3(input t_sample a, input t_sample b,
                                        input t_sample c);
        t_sample lo;
        t_sample hi;
        t_sample med;
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        if (c >= hi) begin
            med = hi;
        end else if (c <= lo) begin
            med = lo;
        end else begin
            med = c;
        end
        return med;
    endfunction

endpackage

### rtl/mgrf_if.sv
// valid/ready channel interfaces for sample words in and filtered words out
// depends on mgrf_pkg
interface mgrf_in_if
    import mgrf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface mgrf_out_if
    import mgrf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

### rtl/mgrf_core.sv
// window state, threshold register and single-pass filter datapath
// depends on mgrf_pkg
module mgrf_core
    import mgrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  t_thresh i_cfg_wr_data,
    input  logic    i_proc,
    input  t_sample i_sample,
    output t_sample o_value
);

    t_thresh r_thresh;
    t_sample r_win [3];
    t_ptr    r_ptr;
    logic    r_full;

    t_ptr    n_ptr;
    logic    n_full;
    t_ptr    cur_slot;
    t_sample prev_val;
    t_sample med_in0;
    t_sample med_in1;
    t_sample med_in2;
    t_sample med_val;
    t_diff   diff_sp;
    t_diff   diff_ps;
    t_diff   abs_diff;
    logic    keep;

    // current slot, its successor and the entry before it
    always_comb begin
        case (r_ptr)
            SLOT_1: begin
                cur_slot = SLOT_1;
                n_ptr    = SLOT_2;
                prev_val = r_win[0];
            end
            SLOT_2: begin
                cur_slot = SLOT_2;
                n_ptr    = SLOT_0;
                prev_val = r_win[1];
            end
            default: begin
                cur_slot = SLOT_0;
                n_ptr    = SLOT_1;
                prev_val = r_win[2];
            end
        endcase
        n_full = r_full || (cur_slot == SLOT_2);
    end

    // exact step size, one bit wider than a sample
    always_comb begin
        diff_sp  = t_diff'({i_sample[SAMPLE_W-1], i_sample})
                 - t_diff'({prev_val[SAMPLE_W-1], prev_val});
        diff_ps  = t_diff'({prev_val[SAMPLE_W-1], prev_val})
                 - t_diff'({i_sample[SAMPLE_W-1], i_sample});
        abs_diff = diff_sp[DIFF_W-1] ? diff_ps : diff_sp;
        keep     = !n_full || (abs_diff < t_diff'(r_thresh));
    end

    // median over the window with the new sample in place
    always_comb begin
        med_in0 = (cur_slot == SLOT_0) ? i_sample : r_win[0];
        med_in1 = (cur_slot == SLOT_1) ? i_sample : r_win[1];
        med_in2 = (cur_slot == SLOT_2) ? i_sample : r_win[2];
        med_val = median3(med_in0, med_in1, med_in2);
    end

    // result select: passthrough in warm-up, median, or held value on a glitch
    always_comb begin
        if (!n_full) begin
            o_value = i_sample;
        end else if (keep) begin
            o_value = med_val;
        end else begin
            o_value = prev_val;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_ptr    <= SLOT_0;
            r_full   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (i_proc) begin
                r_full <= n_full;
                if (keep) begin
                    r_ptr <= n_ptr;
                end
            end
        end
    end

    // window storage, written only by kept samples
    always_ff @(posedge i_clk) begin
        if (i_proc && keep) begin
            r_win[cur_slot] <= i_sample;
        end
    end

endmodule

### rtl/median3_glitch_reject_filter_unit.sv
// Median-of-three glitch reject filter, top level.
// Channels: i_sample (sink) takes one signed sample word per transfer;
// o_result (source) gives one filtered word per accepted sample, in order.
// Both use valid/ready; a word moves on a rising edge with both high.
// i_cfg_wr_en / i_cfg_wr_data write the 31-bit glitch threshold (reset 1000);
// write it only while no sample is in flight.
// Path: an accepted sample is held in the input register, filtered, and
// stored in the result register, from which o_result presents it (one
// input register, one result register).
// Throughput: one sample per cycle while o_result is not stalled; the window update, step check and
// median network all sit between the input register and the result register.
// Warm-up: the first two samples pass through unchanged; from the third
// sample on, samples whose step from the last kept sample reaches the
// threshold are dropped and the last kept sample is output instead.
// Reset (i_rst_n low at a clock edge) empties both registers, clears the
// window pointer and warm-up flag and restores the threshold.
// When the receiver stalls, the result word holds; an empty input register
// still takes one more sample, then i_sample.ready drops until o_result drains.
// depends on mgrf_pkg, mgrf_if, mgrf_core
module median3_glitch_reject_filter_unit
    import mgrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  t_thresh          i_cfg_wr_data,
    mgrf_in_if.sink          i_sample,
    mgrf_out_if.source       o_result
);

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_out_valid;
    t_sample r_out_value;

    logic    n_in_valid;
    logic    n_out_valid;
    logic    out_adv;
    logic    in_take;
    logic    proc;
    t_sample core_value;

    // handshake control
    always_comb begin
        out_adv     = !r_out_valid || o_result.ready;
        proc        = r_in_valid && out_adv;
        in_take     = !r_in_valid || out_adv;
        n_in_valid  = in_take ? i_sample.valid : r_in_valid;
        n_out_valid = out_adv ? r_in_valid : r_out_valid;
    end

    assign i_sample.ready          = in_take;
    assign o_result.valid          = r_out_valid;
    assign o_result.filtered_value = r_out_value;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && i_sample.valid) begin
            r_in_sample <= i_sample.sample_value;
        end
        if (proc) begin
            r_out_value <= core_value;
        end
    end

    // filter datapath and window state
    mgrf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_proc        (proc),
        .i_sample      (r_in_sample),
        .o_value       (core_value)
    );

endmodule

### rtl/mgrf_port_checker.sv
// port-level checks for the median-of-three glitch reject filter top level
// depends on mgrf_pkg and the defines header; bound to the top level below
`include "median3_glitch_reject_filter_unit_defines.svh"

module mgrf_port_checker
    import mgrf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_value
);

    // a stalled result word holds its value
    `MGRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value))

    // a ready receiver never stalls the input side
    `MGRF_ASSERT_IMPL(a_ready_pass, i_clk, i_rst_n, i_out_ready, i_in_ready)

    // the cycle after reset shows no result
    `MGRF_ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid)

    // a new result traces back to a sample taken in through the input register
    `MGRF_ASSERT_IMPL(a_rise_src, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2))

endmodule

bind median3_glitch_reject_filter_unit mgrf_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.filtered_value)
);
